// File: rtl/core/wsd_pkg.sv
package wsd_pkg;

    // default width of the frame length counter
    localparam int LEN_BITS_DEF = 64;

    // limit register reset value
    localparam logic [15:0] MAX_LEN_RESET = 16'd65526;

    // frame header codes
    localparam logic [7:0] OPENER       = 8'h81;
    localparam logic [6:0] CODE_16      = 7'd126;
    localparam logic [6:0] CODE_64      = 7'd127;
    localparam logic [3:0] EXT_64_BYTES = 4'd8;
    localparam logic [3:0] EXT_16_BYTES = 4'd2;

    // one result beat
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       first_of_frame;
        logic       last_of_frame;
        logic       empty_frame;
        logic       oversize_dropped;
    } t_result;

endpackage

// File: rtl/core/wsd_ifs.sv
// received byte channel
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       restart;

    modport source (output valid, output in_byte, output restart, input ready);
    modport sink   (input valid, input in_byte, input restart, output ready);
endinterface

// payload result channel
interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       first_of_frame;
    logic       last_of_frame;
    logic       empty_frame;
    logic       oversize_dropped;

    modport source (
        output valid, output payload_byte, output first_of_frame,
        output last_of_frame, output empty_frame, output oversize_dropped,
        input ready
    );
    modport sink (
        input valid, input payload_byte, input first_of_frame,
        input last_of_frame, input empty_frame, input oversize_dropped,
        output ready
    );
endinterface

// limit register write channel
interface wsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/wsd_parser.sv
module wsd_parser
    import wsd_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_restart,
    input  logic [15:0] i_max_len,
    output logic        o_res_valid,
    output t_result     o_res
);

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_LEN     = 4'b0010,
        PH_EXT     = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [LEN_BITS-1:0] r_count, n_count;
    logic [3:0]          r_ext_left, n_ext_left;
    logic                r_first, n_first;
    logic                r_drop, n_drop;

    logic                s_start;
    logic [LEN_BITS-1:0] s_len;
    logic [LEN_BITS-1:0] s_accum;
    logic [3:0]          s_ext_dec;
    logic                s_last;
    logic                s_over;

    // frame length accumulation, saturating when the top byte is in use
    assign s_accum   = (|r_count[LEN_BITS-1:LEN_BITS-8]) ? {LEN_BITS{1'b1}}
                                                         : {r_count[LEN_BITS-9:0], i_byte};
    assign s_ext_dec = (r_ext_left != 4'd0) ? (r_ext_left - 4'd1) : 4'd0;
    assign s_last    = ~|r_count[LEN_BITS-1:1];
    assign s_over    = s_len > LEN_BITS'(i_max_len);

    // next state and result for one byte
    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_ext_left  = r_ext_left;
        n_first     = r_first;
        n_drop      = r_drop;
        s_start     = 1'b0;
        s_len       = '0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_restart) begin
            n_phase    = PH_HUNT;
            n_count    = '0;
            n_ext_left = 4'd0;
            n_first    = 1'b0;
            n_drop     = 1'b0;
        end else begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_byte == OPENER) begin
                        n_phase    = PH_LEN;
                        n_count    = '0;
                        n_ext_left = 4'd0;
                        n_first    = 1'b0;
                        n_drop     = 1'b0;
                    end
                end
                PH_LEN: begin
                    if (i_byte[6:0] == CODE_16 || i_byte[6:0] == CODE_64) begin
                        n_phase    = PH_EXT;
                        n_count    = '0;
                        n_ext_left = (i_byte[6:0] == CODE_64) ? EXT_64_BYTES : EXT_16_BYTES;
                    end else begin
                        s_start = 1'b1;
                        s_len   = LEN_BITS'(i_byte[6:0]);
                    end
                end
                PH_EXT: begin
                    n_count    = s_accum;
                    n_ext_left = s_ext_dec;
                    if (s_ext_dec == 4'd0) begin
                        s_start = 1'b1;
                        s_len   = s_accum;
                    end
                end
                PH_PAYLOAD: begin
                    if (!r_drop) begin
                        o_res_valid          = 1'b1;
                        o_res.payload_byte   = i_byte;
                        o_res.first_of_frame = r_first;
                        o_res.last_of_frame  = s_last;
                        n_first              = 1'b0;
                    end else if (s_last) begin
                        o_res_valid            = 1'b1;
                        o_res.last_of_frame    = 1'b1;
                        o_res.oversize_dropped = 1'b1;
                    end
                    if (s_last) begin
                        n_phase    = PH_HUNT;
                        n_count    = '0;
                        n_ext_left = 4'd0;
                        n_first    = 1'b0;
                        n_drop     = 1'b0;
                    end else begin
                        n_count = r_count - LEN_BITS'(1);
                    end
                end
                default: begin
                    n_phase    = PH_HUNT;
                    n_count    = '0;
                    n_ext_left = 4'd0;
                    n_first    = 1'b0;
                    n_drop     = 1'b0;
                end
            endcase

            // length complete: empty frame result or enter payload
            if (s_start) begin
                if (s_len == '0) begin
                    o_res_valid          = 1'b1;
                    o_res.first_of_frame = 1'b1;
                    o_res.last_of_frame  = 1'b1;
                    o_res.empty_frame    = 1'b1;
                    n_phase              = PH_HUNT;
                    n_count              = '0;
                    n_ext_left           = 4'd0;
                    n_first              = 1'b0;
                    n_drop               = 1'b0;
                end else begin
                    n_phase    = PH_PAYLOAD;
                    n_count    = s_len;
                    n_ext_left = 4'd0;
                    n_drop     = s_over;
                    n_first    = !s_over;
                end
            end
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_count    <= '0;
            r_ext_left <= 4'd0;
            r_first    <= 1'b0;
            r_drop     <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_ext_left <= n_ext_left;
            r_first    <= n_first;
            r_drop     <= n_drop;
        end
    end

endmodule

// File: rtl/core/websocket_frame_deframer.sv
// path: input register, combinational frame parser, result register
// throughput: one byte per cycle while the result register is not stalled; the frame parser state is registered
// the input register takes a byte while the result register holds a stalled beat only if it is empty
// reset: synchronous active low; parser returns to hunting, limit goes to 65526,
// both pipeline registers come up empty
module websocket_frame_deframer
    import wsd_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wsd_in_if.sink    i_in,
    wsd_out_if.source o_out,
    wsd_cfg_if.sink   i_cfg
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_restart;
    logic        r_out_valid;
    t_result     r_out;
    logic [15:0] r_max_len;

    logic        s_adv;
    logic        s_step;
    logic        s_res_valid;
    t_result     s_res;

    assign s_adv      = !r_out_valid || o_out.ready;
    assign s_step     = r_in_valid && s_adv;
    assign i_in.ready = !r_in_valid || s_adv;
    assign i_cfg.ready = 1'b1;

    // limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg.valid) begin
            r_max_len <= i_cfg.data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte    <= i_in.in_byte;
            r_in_restart <= i_in.restart;
        end
    end

    wsd_parser #(
        .LEN_BITS (LEN_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s_step),
        .i_byte      (r_in_byte),
        .i_restart   (r_in_restart),
        .i_max_len   (r_max_len),
        .o_res_valid (s_res_valid),
        .o_res       (s_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_adv) begin
            r_out_valid <= s_step && s_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_out <= s_res;
        end
    end

    // result beat
    assign o_out.valid            = r_out_valid;
    assign o_out.payload_byte     = r_out.payload_byte;
    assign o_out.first_of_frame   = r_out.first_of_frame;
    assign o_out.last_of_frame    = r_out.last_of_frame;
    assign o_out.empty_frame      = r_out.empty_frame;
    assign o_out.oversize_dropped = r_out.oversize_dropped;

endmodule

// File: tb/websocket_frame_deframer_tb.sv
module websocket_frame_deframer_tb
    import wsd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_W = LEN_BITS_DEF;
    localparam logic [LEN_W-1:0] LEN_ALL = '1;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTED = 30;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_EXT,
        PH_PAYLOAD
    } t_parse_phase;

    typedef enum int {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } t_len_form;

    // one beat on the byte channel
    typedef struct packed {
        logic [7:0] b;
        logic       rs;
    } t_stream_beat;

    logic i_clk;
    logic i_rst_n;

    wsd_in_if  in_if ();
    wsd_out_if out_if ();
    wsd_cfg_if cfg_if ();

    websocket_frame_deframer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // byte stream waiting to be sent, and payload beats due from the block
    t_stream_beat stream_q[$];
    t_result      payload_beats_due[$];

    // deframer state as predicted
    t_parse_phase   ph;
    logic [LEN_W-1:0] len_acc;
    logic [3:0]     ext_left;
    logic [LEN_W-1:0] pay_left;
    logic           first_pend;
    logic           dropping;
    logic [15:0]    byte_limit;

    int err_count;
    int fed_count;
    int in_gap, in_burst;
    int out_stall, out_burst;
    t_stream_beat next_beat;
    t_result got_beat, due_beat;

    // clock
    always #5 i_clk = ~i_clk;

    task automatic report(input string msg);
        if (err_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // gap before the next beat: mostly none or short, a few long, bursts with none
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
            burst = $urandom_range(20, 60);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic void hunt_reset();
        ph = PH_HUNT;
        len_acc = '0;
        ext_left = '0;
        pay_left = '0;
        first_pend = 1'b0;
        dropping = 1'b0;
    endfunction

    // length known: either an empty-frame beat or the start of the payload
    function automatic void open_payload(input logic [LEN_W-1:0] len,
                                         output t_result r, output bit hit);
        r = '0;
        hit = 0;
        if (len == '0) begin
            r.first_of_frame = 1'b1;
            r.last_of_frame = 1'b1;
            r.empty_frame = 1'b1;
            hit = 1;
            hunt_reset();
        end else begin
            ph = PH_PAYLOAD;
            pay_left = len;
            len_acc = len;
            ext_left = '0;
            dropping = (len > LEN_W'(byte_limit));
            first_pend = ~dropping;
        end
    endfunction

    // advance the deframer by one byte, queue the beat it yields if any
    function automatic void deframe_byte(input logic [7:0] b, input logic rs);
        t_result r;
        bit hit;
        logic [6:0] code;
        logic fin;
        r = '0;
        hit = 0;
        if (rs) begin
            hunt_reset();
        end else begin
            case (ph)
                PH_HUNT: begin
                    if (b == OPENER) begin
                        hunt_reset();
                        ph = PH_LEN;
                    end
                end
                PH_LEN: begin
                    code = b[6:0];
                    if (code == CODE_16 || code == CODE_64) begin
                        ph = PH_EXT;
                        len_acc = '0;
                        ext_left = (code == CODE_64) ? EXT_64_BYTES : EXT_16_BYTES;
                    end else begin
                        open_payload(LEN_W'(code), r, hit);
                    end
                end
                PH_EXT: begin
                    if (len_acc > (LEN_ALL >> 8))
                        len_acc = LEN_ALL;
                    else
                        len_acc = {len_acc[LEN_W-9:0], b};
                    if (ext_left > 0)
                        ext_left = ext_left - 4'd1;
                    if (ext_left == 0)
                        open_payload(len_acc, r, hit);
                end
                default: begin
                    fin = (pay_left <= 1);
                    if (dropping) begin
                        if (fin) begin
                            r.last_of_frame = 1'b1;
                            r.oversize_dropped = 1'b1;
                            hit = 1;
                            hunt_reset();
                        end else begin
                            pay_left = pay_left - 1'b1;
                        end
                    end else begin
                        r.payload_byte = b;
                        r.first_of_frame = first_pend;
                        r.last_of_frame = fin;
                        hit = 1;
                        first_pend = 1'b0;
                        if (fin)
                            hunt_reset();
                        else
                            pay_left = pay_left - 1'b1;
                    end
                end
            endcase
        end
        if (hit)
            payload_beats_due.push_back(r);
    endfunction

    // byte driver: predicts each accepted beat, then loads the next one after a gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                deframe_byte(in_if.in_byte, in_if.restart);
            if (!in_if.valid || in_if.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_if.valid <= 1'b0;
                end else if (stream_q.size() > 0) begin
                    next_beat = stream_q.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.in_byte <= next_beat.b;
                    in_if.restart <= next_beat.rs;
                    in_gap = pick_gap(in_burst);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got_beat.payload_byte = out_if.payload_byte;
                got_beat.first_of_frame = out_if.first_of_frame;
                got_beat.last_of_frame = out_if.last_of_frame;
                got_beat.empty_frame = out_if.empty_frame;
                got_beat.oversize_dropped = out_if.oversize_dropped;
                if (payload_beats_due.size() == 0) begin
                    report($sformatf("unexpected result beat %h", got_beat));
                end else begin
                    due_beat = payload_beats_due.pop_front();
                    if (got_beat.payload_byte !== due_beat.payload_byte)
                        report($sformatf("payload_byte got %h want %h",
                                         got_beat.payload_byte, due_beat.payload_byte));
                    if (got_beat.first_of_frame !== due_beat.first_of_frame)
                        report($sformatf("first_of_frame got %b want %b",
                                         got_beat.first_of_frame, due_beat.first_of_frame));
                    if (got_beat.last_of_frame !== due_beat.last_of_frame)
                        report($sformatf("last_of_frame got %b want %b",
                                         got_beat.last_of_frame, due_beat.last_of_frame));
                    if (got_beat.empty_frame !== due_beat.empty_frame)
                        report($sformatf("empty_frame got %b want %b",
                                         got_beat.empty_frame, due_beat.empty_frame));
                    if (got_beat.oversize_dropped !== due_beat.oversize_dropped)
                        report($sformatf("oversize_dropped got %b want %b",
                                         got_beat.oversize_dropped,
                                         due_beat.oversize_dropped));
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                out_stall = pick_gap(out_burst);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic rs);
        stream_q.push_back({b, rs});
        fed_count++;
    endtask

    // opener, length header in the given form, payload; a cut stops the
    // payload early with a restart beat
    task automatic push_frame(input logic [63:0] len, input t_len_form form, input int cut);
        logic mask;
        int n;
        mask = $urandom_range(0, 1);
        push_byte(OPENER, 1'b0);
        case (form)
            FORM_SHORT: push_byte({mask, len[6:0]}, 1'b0);
            FORM_EXT16: begin
                push_byte({mask, CODE_16}, 1'b0);
                push_byte(len[15:8], 1'b0);
                push_byte(len[7:0], 1'b0);
            end
            default: begin
                push_byte({mask, CODE_64}, 1'b0);
                for (int i = 7; i >= 0; i--)
                    push_byte(len[i*8 +: 8], 1'b0);
            end
        endcase
        n = (cut >= 0) ? cut : int'(len);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom), 1'b0);
        if (cut >= 0)
            push_byte(8'($urandom), 1'b1);
    endtask

    function automatic t_len_form pick_form(input logic [63:0] len);
        if (len < 126 && $urandom_range(0, 9) < 6)
            return FORM_SHORT;
        if (len < 65536 && $urandom_range(0, 1) == 0)
            return FORM_EXT16;
        return FORM_EXT64;
    endfunction

    // random traffic: mostly well-formed frames, some noise and broken frames
    task automatic run_random(input int n_items, input int max_len);
        int stop_at;
        int r;
        logic [63:0] len;
        stop_at = fed_count + n_items;
        while (fed_count < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 58) begin
                if ($urandom_range(0, 29) == 0)
                    len = $urandom_range(126, 300);
                else
                    len = $urandom_range(0, max_len);
                push_frame(len, pick_form(len), -1);
            end else if (r < 68) begin
                // lengths around the limit
                len = byte_limit + $urandom_range(0, 2);
                len = (len == 0) ? 0 : len - 1;
                if (len <= 64)
                    push_frame(len, pick_form(len), -1);
            end else if (r < 78) begin
                repeat ($urandom_range(1, 5))
                    push_byte(8'($urandom), 1'b0);
            end else if (r < 85) begin
                push_byte(8'($urandom), 1'b1);
            end else if (r < 93) begin
                len = $urandom_range(2, max_len + 2);
                push_frame(len, pick_form(len), $urandom_range(0, int'(len) - 1));
            end else if (r < 97) begin
                // header broken off by a restart
                push_byte(OPENER, 1'b0);
                if ($urandom_range(0, 1)) begin
                    push_byte({1'($urandom), ($urandom_range(0, 1) ? CODE_64 : CODE_16)},
                              1'b0);
                    repeat ($urandom_range(0, 1))
                        push_byte(8'($urandom), 1'b0);
                end
                push_byte(8'($urandom), 1'b1);
            end else begin
                // huge 64-bit length, abandoned after a few bytes
                len = {$urandom, $urandom};
                len[63] = 1'b1;
                if ($urandom_range(0, 1))
                    len = '1;
                push_frame(len, FORM_EXT64, $urandom_range(0, 6));
            end
        end
    endtask

    // let the stream run dry and every due beat come out
    task automatic drain_idle();
        int spins;
        spins = 0;
        while (stream_q.size() != 0 || in_if.valid)
            @(posedge i_clk);
        while (payload_beats_due.size() != 0 && spins < 5000) begin
            @(posedge i_clk);
            spins++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        drain_idle();
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= v;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        byte_limit = v;
        repeat (2) @(posedge i_clk);
    endtask

    // stimulus sequence
    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.in_byte = '0;
        in_if.restart = 1'b0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        err_count = 0;
        fed_count = 0;
        in_gap = 0;
        in_burst = 0;
        out_stall = 0;
        out_burst = 0;
        byte_limit = MAX_LEN_RESET;
        hunt_reset();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: noise, restart on an opener, empty and masked-empty frames,
        // single byte, zero via 16-bit length, 64-bit length, cut frame, saturated length
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(OPENER, 1'b1);
        push_byte(8'h00, 1'b0);
        push_frame(64'd0, FORM_SHORT, -1);
        push_byte(OPENER, 1'b0);
        push_byte(8'h80, 1'b0);
        push_frame(64'd1, FORM_SHORT, -1);
        push_frame(64'd0, FORM_EXT16, -1);
        push_frame(64'd2, FORM_EXT64, -1);
        push_frame(64'd3, FORM_SHORT, 1);
        push_frame('1, FORM_EXT64, 2);
        run_random(380, 12);

        // every non-empty frame is over the limit
        write_limit(16'd0);
        push_frame(64'd1, FORM_SHORT, -1);
        push_frame(64'd0, FORM_SHORT, -1);
        run_random(320, 8);

        // widest limit
        write_limit(16'hFFFF);
        run_random(360, 20);

        // small limits, boundary lengths land on both sides
        write_limit(16'($urandom_range(1, 16)));
        run_random(380, 20);

        write_limit(16'd3);
        run_random(320, 8);

        drain_idle();
        if (payload_beats_due.size() != 0)
            report($sformatf("%0d result beats never arrived", payload_beats_due.size()));
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
